// ===== rtl/core/mlfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlfd_pkg: shared types and constants of the frame deframer
// Result request layout, result kinds, queue status and register reset value.
// ----------------------------------------------------------------------------
package mlfd_pkg;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REJECT  = 1'b1;

    localparam logic [31:0] MAX_PAYLOAD_LEN_RESET = 32'd8388608;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic        first_of_frame;
        logic        last_of_frame;
        logic [31:0] frame_number;
        logic [31:0] frame_length;
    } result_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mlfd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlfd_front: byte parser
// Hunts for the sync word, collects the length, checks it and tags payload
// bytes; every byte that yields a result pushes one request into the queue.
// ----------------------------------------------------------------------------
module mlfd_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_data_byte,
    input  wire logic [31:0]         max_len,
    input  wire mlfd_pkg::q_status_t q_stat,
    output logic                     push,
    output mlfd_pkg::result_t        push_data
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;

    localparam logic [7:0] SYNC_F = 8'h46;
    localparam logic [7:0] SYNC_R = 8'h52;
    localparam logic [7:0] SYNC_A = 8'h41;
    localparam logic [7:0] SYNC_M = 8'h4D;

    // {done, next match count}
    function automatic logic [2:0] sync_step(input logic [1:0] m, input logic [7:0] b);
        logic [7:0] expect_b;
        logic [2:0] r;
        unique case (m)
            2'd0:    expect_b = SYNC_F;
            2'd1:    expect_b = SYNC_R;
            2'd2:    expect_b = SYNC_A;
            default: expect_b = SYNC_M;
        endcase
        if (b == expect_b) begin
            r = (m == 2'd3) ? 3'b100 : {1'b0, m + 2'd1};
        end else begin
            r = (b == SYNC_F) ? 3'b001 : 3'b000;
        end
        return r;
    endfunction

    logic [1:0]  phase_reg,     phase_next;
    logic [1:0]  match_reg,     match_next;
    logic [31:0] len_shift_reg, len_shift_next;
    logic [1:0]  len_seen_reg,  len_seen_next;
    logic [31:0] remain_reg,    remain_next;
    logic [31:0] frame_cnt_reg, frame_cnt_next;

    logic        accept;
    logic [31:0] new_len;
    logic [2:0]  hunt_st;
    logic [2:0]  rs0, rs1, rs2, rs3;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign new_len = {s_data_byte, len_shift_reg[31:8]};
    assign hunt_st = sync_step(match_reg, s_data_byte);

    // Rescan of the rejected length bytes, starting from nothing matched.
    // From zero matched the word can only complete on the fourth byte.
    assign rs0 = sync_step(2'd0,     new_len[7:0]);
    assign rs1 = sync_step(rs0[1:0], new_len[15:8]);
    assign rs2 = sync_step(rs1[1:0], new_len[23:16]);
    assign rs3 = sync_step(rs2[1:0], new_len[31:24]);

    always_comb begin
        phase_next     = phase_reg;
        match_next     = match_reg;
        len_shift_next = len_shift_reg;
        len_seen_next  = len_seen_reg;
        remain_next    = remain_reg;
        frame_cnt_next = frame_cnt_reg;
        push           = 1'b0;
        push_data      = '0;
        if (accept) begin
            unique case (phase_reg)
                PH_LEN: begin
                    len_shift_next = new_len;
                    if (len_seen_reg != 2'd3) begin
                        len_seen_next = len_seen_reg + 2'd1;
                    end else begin
                        len_seen_next = 2'd0;
                        if (new_len == 32'd0 || new_len > max_len) begin
                            push                   = 1'b1;
                            push_data.result_kind  = mlfd_pkg::KIND_REJECT;
                            push_data.frame_number = frame_cnt_reg;
                            push_data.frame_length = new_len;
                            if (rs3[2]) begin
                                phase_next     = PH_LEN;
                                match_next     = 2'd0;
                                len_shift_next = 32'd0;
                            end else begin
                                phase_next = PH_HUNT;
                                match_next = rs3[1:0];
                            end
                        end else begin
                            remain_next = new_len;
                            phase_next  = PH_PAY;
                        end
                    end
                end
                PH_PAY: begin
                    push                     = 1'b1;
                    push_data.result_kind    = mlfd_pkg::KIND_PAYLOAD;
                    push_data.payload_byte   = s_data_byte;
                    push_data.first_of_frame = (remain_reg == len_shift_reg);
                    push_data.last_of_frame  = (remain_reg == 32'd1);
                    push_data.frame_number   = frame_cnt_reg;
                    push_data.frame_length   = len_shift_reg;
                    if (remain_reg <= 32'd1) begin
                        remain_next    = 32'd0;
                        phase_next     = PH_HUNT;
                        match_next     = 2'd0;
                        frame_cnt_next = frame_cnt_reg + 32'd1;
                    end else begin
                        remain_next = remain_reg - 32'd1;
                    end
                end
                default: begin
                    // hunting; the unused code behaves the same
                    phase_next = PH_HUNT;
                    match_next = hunt_st[1:0];
                    if (hunt_st[2]) begin
                        phase_next     = PH_LEN;
                        len_shift_next = 32'd0;
                        len_seen_next  = 2'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            match_reg     <= 2'd0;
            len_shift_reg <= 32'd0;
            len_seen_reg  <= 2'd0;
            remain_reg    <= 32'd0;
            frame_cnt_reg <= 32'd0;
        end else begin
            phase_reg     <= phase_next;
            match_reg     <= match_next;
            len_shift_reg <= len_shift_next;
            len_seen_reg  <= len_seen_next;
            remain_reg    <= remain_next;
            frame_cnt_reg <= frame_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mlfd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlfd_queue: result request queue
// Small circular buffer between parser and output stage.
// ----------------------------------------------------------------------------
module mlfd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire mlfd_pkg::result_t push_data,
    input  wire logic              pop,
    output mlfd_pkg::result_t      head,
    output mlfd_pkg::q_status_t    q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mlfd_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign head            = mem[rd_ptr_reg];
    assign q_stat.full     = (count_reg == CNT_FULL);
    assign q_stat.nonempty = (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mlfd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlfd_back: output stage
// Takes requests from the queue into the output register and hands them on.
// ----------------------------------------------------------------------------
module mlfd_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mlfd_pkg::q_status_t q_stat,
    input  wire mlfd_pkg::result_t   head,
    output logic                     pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_result_kind,
    output logic [7:0]               m_payload_byte,
    output logic                     m_first_of_frame,
    output logic                     m_last_of_frame,
    output logic [31:0]              m_frame_number,
    output logic [31:0]              m_frame_length
);

    logic              valid_reg;
    mlfd_pkg::result_t out_reg;

    // advance when the register is empty or being drained
    assign pop = q_stat.nonempty && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= head;
        end
    end

    assign m_valid          = valid_reg;
    assign m_result_kind    = out_reg.result_kind;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_first_of_frame = out_reg.first_of_frame;
    assign m_last_of_frame  = out_reg.last_of_frame;
    assign m_frame_number   = out_reg.frame_number;
    assign m_frame_length   = out_reg.frame_length;

endmodule

`default_nettype wire

// ===== rtl/core/magic_length_frame_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// magic_length_frame_deframer: sync word and length prefixed frame deframer
// Byte stream in; payload bytes and bad-length reports out.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle. It hunts for the sync word "FRAM",
// reads a 32-bit little-endian length and passes the payload bytes on with
// first/last marks, the frame number and the length. A length of zero or above
// cfg max_payload_len gives one reject result; the four length bytes are then
// searched for a new sync word. A byte is parsed in the cycle it is accepted
// and its result enters a QUEUE_DEPTH-entry queue; the output register takes
// it from the queue when it is empty or being drained and holds it until
// m_ready. s_ready falls only when the queue is full, i.e. after the result
// side has stalled; otherwise a byte goes in every cycle.
// Write max_payload_len (cfg_we/cfg_wdata) only while no frame is in flight.
// ----------------------------------------------------------------------------
module magic_length_frame_deframer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_result_kind,
    output logic [7:0]       m_payload_byte,
    output logic             m_first_of_frame,
    output logic             m_last_of_frame,
    output logic [31:0]      m_frame_number,
    output logic [31:0]      m_frame_length
);

    logic [31:0]         max_len_reg;
    logic                push;
    logic                pop;
    mlfd_pkg::result_t   push_data;
    mlfd_pkg::result_t   head;
    mlfd_pkg::q_status_t q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= mlfd_pkg::MAX_PAYLOAD_LEN_RESET;
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

    mlfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .max_len     (max_len_reg),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data)
    );

    mlfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    mlfd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_stat           (q_stat),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_payload_byte   (m_payload_byte),
        .m_first_of_frame (m_first_of_frame),
        .m_last_of_frame  (m_last_of_frame),
        .m_frame_number   (m_frame_number),
        .m_frame_length   (m_frame_length)
    );

`ifndef NO_ASSERTIONS
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (s_valid && s_ready))
        else $error("result pushed without an accepted byte");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_stat.nonempty)
        else $error("queue popped while empty");

    a_full_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> q_stat.nonempty)
        else $error("queue status inconsistent");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == mlfd_pkg::KIND_REJECT) |->
            (m_payload_byte == 8'd0 && !m_first_of_frame && !m_last_of_frame))
        else $error("reject result carries payload marks");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/magic_length_frame_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// magic_length_frame_deframer_tb: self-checking bench for the frame deframer
// Feeds byte streams of sync words, length headers and payload under several
// max_payload_len settings and idle patterns, predicts every payload byte and
// bad-length report, and checks the result channel field by field in order.
// ----------------------------------------------------------------------------
module magic_length_frame_deframer_tb;

    typedef enum logic [1:0] {
        HUNT     = 2'd0,
        READ_LEN = 2'd1,
        PAYLOAD  = 2'd2
    } deframe_phase_t;

    localparam logic [7:0]  SYNC_F         = 8'h46;
    localparam logic [7:0]  SYNC_R         = 8'h52;
    localparam logic [7:0]  SYNC_A         = 8'h41;
    localparam logic [7:0]  SYNC_M         = 8'h4D;
    // "FRAM" read as a little-endian length
    localparam logic [31:0] SYNC_AS_LENGTH = {SYNC_M, SYNC_A, SYNC_R, SYNC_F};
    localparam logic [31:0] MAX_ALL_ONES   = 32'hFFFF_FFFF;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int unsigned CYCLE_LIMIT    = 400000;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [31:0] cfg_wdata   = '0;
    logic        s_valid     = 1'b0;
    logic [7:0]  s_data_byte = '0;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_result_kind;
    logic [7:0]  m_payload_byte;
    logic        m_first_of_frame;
    logic        m_last_of_frame;
    logic [31:0] m_frame_number;
    logic [31:0] m_frame_length;

    magic_length_frame_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_payload_byte   (m_payload_byte),
        .m_first_of_frame (m_first_of_frame),
        .m_last_of_frame  (m_last_of_frame),
        .m_frame_number   (m_frame_number),
        .m_frame_length   (m_frame_length)
    );

    always #5 aclk = ~aclk;

    logic [7:0]        byte_stream[$];
    mlfd_pkg::result_t predicted_results[$];
    mlfd_pkg::result_t want;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    // deframer state as the bench sees it
    deframe_phase_t ph        = HUNT;
    logic [2:0]     sync_cnt  = '0;
    logic [31:0]    len_shift = '0;
    logic [1:0]     len_seen  = '0;
    logic [31:0]    remaining = '0;
    logic [31:0]    frame_ctr = '0;
    logic [31:0]    max_len   = mlfd_pkg::MAX_PAYLOAD_LEN_RESET;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_error($sformatf("%s: got %0h, expected %0h", name, got, exp_val));
    endtask

    function automatic void sync_advance(input logic [7:0] b);
        logic [1:0] m;
        m = sync_cnt[1:0];
        if (b == SYNC_AS_LENGTH[{m, 3'b000} +: 8]) begin
            if (m == 2'd3) begin
                sync_cnt  = '0;
                ph        = READ_LEN;
                len_shift = '0;
                len_seen  = '0;
            end else begin
                sync_cnt = {1'b0, m} + 3'd1;
            end
        end else begin
            sync_cnt = (b == SYNC_F) ? 3'd1 : 3'd0;
        end
    endfunction

    function automatic void deframe_predict(input logic [7:0] b);
        mlfd_pkg::result_t r;
        logic [31:0]       bad;
        r = '0;
        case (ph)
            READ_LEN: begin
                len_shift = {b, len_shift[31:8]};
                if (len_seen != 2'd3) begin
                    len_seen = len_seen + 2'd1;
                end else begin
                    len_seen = '0;
                    if (len_shift == '0 || len_shift > max_len) begin
                        r.result_kind  = mlfd_pkg::KIND_REJECT;
                        r.frame_number = frame_ctr;
                        r.frame_length = len_shift;
                        predicted_results.push_back(r);
                        bad      = len_shift;
                        ph       = HUNT;
                        sync_cnt = '0;
                        // rescan the length bytes; a sync found inside them starts a new header
                        for (int k = 0; k < 4; k++) begin
                            if (ph == HUNT) begin
                                sync_advance(bad[8*k +: 8]);
                            end else begin
                                len_shift = {bad[8*k +: 8], len_shift[31:8]};
                                len_seen  = len_seen + 2'd1;
                            end
                        end
                    end else begin
                        remaining = len_shift;
                        ph        = PAYLOAD;
                    end
                end
            end
            PAYLOAD: begin
                r.result_kind    = mlfd_pkg::KIND_PAYLOAD;
                r.payload_byte   = b;
                r.first_of_frame = (remaining == len_shift);
                r.last_of_frame  = (remaining == 32'd1);
                r.frame_number   = frame_ctr;
                r.frame_length   = len_shift;
                predicted_results.push_back(r);
                if (remaining <= 32'd1) begin
                    remaining = '0;
                    ph        = HUNT;
                    sync_cnt  = '0;
                    frame_ctr = frame_ctr + 32'd1;
                end else begin
                    remaining = remaining - 32'd1;
                end
            end
            default: begin
                ph = HUNT;
                sync_advance(b);
            end
        endcase
    endfunction

    // driver: hold the request until accepted, then offer the next byte
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                deframe_predict(s_data_byte);
            if (!s_valid || s_ready) begin
                if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid     <= 1'b1;
                    s_data_byte <= byte_stream.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each delivered result against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_error($sformatf("unexpected result kind %0d byte %02h len %0h",
                                           m_result_kind, m_payload_byte, m_frame_length));
                end else begin
                    want = predicted_results.pop_front();
                    check_field("result_kind", m_result_kind, want.result_kind);
                    check_field("payload_byte", m_payload_byte, want.payload_byte);
                    check_field("first_of_frame", m_first_of_frame, want.first_of_frame);
                    check_field("last_of_frame", m_last_of_frame, want.last_of_frame);
                    check_field("frame_number", m_frame_number, want.frame_number);
                    check_field("frame_length", m_frame_length, want.frame_length);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_sync();
        byte_stream.push_back(SYNC_F);
        byte_stream.push_back(SYNC_R);
        byte_stream.push_back(SYNC_A);
        byte_stream.push_back(SYNC_M);
    endtask

    task automatic push_len(input logic [31:0] v);
        for (int k = 0; k < 4; k++)
            byte_stream.push_back(v[8*k +: 8]);
    endtask

    task automatic push_accepted_frame();
        logic [31:0] v;
        int unsigned cap;
        int unsigned len;
        if (max_len == '0) begin
            // nothing can pass: send a random header that is bound to be refused
            v = $urandom;
            if (v == SYNC_AS_LENGTH)
                v = '0;
            push_len(v);
        end else begin
            cap = (max_len < 32'd12) ? max_len : 12;
            len = $urandom_range(cap, 1);
            push_len(len);
            repeat (len) byte_stream.push_back(8'($urandom));
        end
    endtask

    task automatic add_random_unit();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  v8;
        logic [63:0] lo;
        pick = $urandom_range(99);
        if (pick < 12) begin
            // line noise, biased towards the sync lead byte; never completes a sync
            n = $urandom_range(6, 1);
            repeat (n) begin
                v8 = 8'($urandom);
                if ($urandom_range(3) == 0)
                    v8 = SYNC_F;
                if (v8 == SYNC_M)
                    v8 = 8'h00;
                byte_stream.push_back(v8);
            end
        end else if (pick < 22) begin
            // broken sync word
            n = $urandom_range(3, 1);
            for (int k = 0; k < n; k++)
                byte_stream.push_back(SYNC_AS_LENGTH[8*k +: 8]);
            v8 = 8'($urandom);
            if (v8 == SYNC_AS_LENGTH[8*n +: 8])
                v8 = v8 ^ 8'h01;
            byte_stream.push_back(v8);
        end else begin
            push_sync();
            if (pick < 35) begin
                push_len('0);
            end else if (pick < 48 && max_len != MAX_ALL_ONES) begin
                lo = {32'd0, max_len} + 64'd1;
                if ($urandom_range(1) == 0)
                    push_len(lo[31:0]);
                else
                    push_len(32'(lo[31:0] + ($urandom % (64'h1_0000_0000 - lo))));
            end else if (pick < 55 && max_len < SYNC_AS_LENGTH) begin
                // refused length that is itself a sync word: the next header follows
                push_len(SYNC_AS_LENGTH);
                push_accepted_frame();
            end else begin
                push_accepted_frame();
            end
        end
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (byte_stream.size() != 0 || s_valid || predicted_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_max_len(input logic [31:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        max_len = v;
        @(negedge aclk);
    endtask

    task automatic run_phase(input logic [31:0] new_max, input int unsigned n_bytes);
        write_max_len(new_max);
        while (byte_stream.size() < n_bytes)
            add_random_unit();
        drain();
        // finish any frame still open before the register is touched again
        while (ph != HUNT) begin
            repeat (8) byte_stream.push_back(8'h00);
            drain();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct  = 15;
        recv_stall_pct = 88;

        // sync restart on a repeated lead byte, then a zero length
        byte_stream.push_back(SYNC_F);
        push_sync();
        push_len('0);
        // length that spells the sync word: refused, then read as a new header
        push_sync();
        push_len(SYNC_AS_LENGTH);
        // one above the reset maximum
        push_len(mlfd_pkg::MAX_PAYLOAD_LEN_RESET + 32'd1);
        // single-byte frame carrying all ones
        push_sync();
        push_len(32'd1);
        byte_stream.push_back(8'hFF);
        while (byte_stream.size() < 250)
            add_random_unit();
        drain();
        while (ph != HUNT) begin
            repeat (8) byte_stream.push_back(8'h00);
            drain();
        end

        run_phase(32'd0, 100);

        send_idle_pct  = 88;
        recv_stall_pct = 15;
        run_phase(32'd1, 200);
        run_phase(MAX_ALL_ONES, 200);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_phase(32'd6, 250);
        run_phase(mlfd_pkg::MAX_PAYLOAD_LEN_RESET, 120);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mlfd_pkg.sv
rtl/core/mlfd_front.sv
rtl/core/mlfd_queue.sv
rtl/core/mlfd_back.sv
rtl/core/magic_length_frame_deframer.sv
tb/sv/magic_length_frame_deframer_tb.sv
